### hdl/byte_stream_reassembler_top_assert.svh
// ---------------------------------------------------------------------------
// byte_stream_reassembler_top_assert.svh
// assertion macros for the byte stream reassembler
// ---------------------------------------------------------------------------
`ifndef BYTE_STREAM_REASSEMBLER_TOP_ASSERT_SVH
`define BYTE_STREAM_REASSEMBLER_TOP_ASSERT_SVH

`ifndef SYNTH

`define BSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsr assertion failed");

`define BSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsr assertion failed");

`else

`define BSR_ASSERT_IMP(lbl, ante, cons)

`define BSR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hdl/bsr_pkg.sv
// ---------------------------------------------------------------------------
// bsr_pkg
// shared constants and types of the byte stream reassembler
// ---------------------------------------------------------------------------
package bsr_pkg;

  localparam int CAPACITY   = 64;
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int POS_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ
  } bsr_state_t;

  typedef struct packed {
    logic accept;
    logic rel;
    logic emit_byte;
    logic emit_empty;
  } bsr_cmd_t;

  typedef struct packed {
    logic head_valid;
    logic out_free;
  } bsr_sts_t;

endpackage

### hdl/bsr_dp.sv
// ---------------------------------------------------------------------------
// bsr_dp
// datapath: byte ring, slot valid bits, stream pointers and result register
// ---------------------------------------------------------------------------
module bsr_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bsr_pkg::bsr_cmd_t         cmd,
  output bsr_pkg::bsr_sts_t         sts,
  input  logic [bsr_pkg::POS_W-1:0]  in_position,
  input  logic [bsr_pkg::BYTE_W-1:0] in_byte_value,
  input  logic                      in_has_byte,
  input  logic                      in_ends_stream,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [bsr_pkg::BYTE_W-1:0] out_out_byte,
  output logic                      out_out_valid,
  output logic                      out_run_last,
  output logic                      out_stream_done,
  output logic [bsr_pkg::CNT_W-1:0]  out_pending_count
);
  import bsr_pkg::*;

  localparam logic [POS_W-1:0] CAP_W = POS_W'(CAPACITY);

  logic [BYTE_W-1:0]     ring_mem [RING_DEPTH];
  logic [BYTE_W-1:0]     rd_data_r;
  logic [RING_DEPTH-1:0] slot_valid_r, slot_valid_nxt;
  logic [POS_W-1:0]      next_exp_r, next_exp_nxt;
  logic [POS_W-1:0]      end_pos_r, end_pos_nxt;
  logic                  end_known_r, end_known_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r;
  logic                  out_bvalid_r;
  logic                  out_last_r;
  logic                  out_done_r;
  logic [CNT_W-1:0]      out_pend_r;

  logic [RING_AW-1:0]    head_slot;
  logic [RING_AW-1:0]    in_slot;
  logic [POS_W-1:0]      ahead;
  logic                  in_win;
  logic                  done_now;

  assign head_slot = next_exp_r[RING_AW-1:0];
  assign in_slot   = in_position[RING_AW-1:0];
  assign ahead     = in_position - next_exp_r;
  assign in_win    = in_has_byte && (ahead < CAP_W);
  assign done_now  = end_known_r && (next_exp_r == end_pos_r);

  assign sts.head_valid = slot_valid_r[head_slot];
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    next_exp_nxt   = next_exp_r;
    end_pos_nxt    = end_pos_r;
    end_known_nxt  = end_known_r;
    count_nxt      = count_r;
    if (cmd.accept) begin
      if (in_ends_stream) begin
        end_known_nxt = 1'b1;
        end_pos_nxt   = in_position + POS_W'(in_has_byte);
      end
      if (in_win) begin
        slot_valid_nxt[in_slot] = 1'b1;
        if (!slot_valid_r[in_slot]) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
    if (cmd.rel) begin
      slot_valid_nxt[head_slot] = 1'b0;
      count_nxt                 = count_r - CNT_W'(1);
      next_exp_nxt              = next_exp_r + POS_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_byte || cmd.emit_empty) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      next_exp_r   <= '0;
      end_pos_r    <= '0;
      end_known_r  <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      next_exp_r   <= next_exp_nxt;
      end_pos_r    <= end_pos_nxt;
      end_known_r  <= end_known_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // byte ring, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && in_win) begin
      ring_mem[in_slot] <= in_byte_value;
    end
    if (cmd.rel) begin
      rd_data_r <= ring_mem[head_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_byte_r   <= rd_data_r;
      out_bvalid_r <= 1'b1;
      out_last_r   <= !slot_valid_r[head_slot];
      out_done_r   <= done_now;
      out_pend_r   <= count_r;
    end else if (cmd.emit_empty) begin
      out_byte_r   <= '0;
      out_bvalid_r <= 1'b0;
      out_last_r   <= 1'b1;
      out_done_r   <= done_now;
      out_pend_r   <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_out_byte      = out_byte_r;
  assign out_out_valid     = out_bvalid_r;
  assign out_run_last      = out_last_r;
  assign out_stream_done   = out_done_r;
  assign out_pending_count = out_pend_r;

endmodule

### hdl/bsr_ctrl.sv
// ---------------------------------------------------------------------------
// bsr_ctrl
// controller: sequences store, release and result transfer per item
// ---------------------------------------------------------------------------
module bsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bsr_pkg::bsr_sts_t sts,
  output bsr_pkg::bsr_cmd_t cmd
);
  import bsr_pkg::*;

  bsr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.head_valid) begin
          cmd.rel   = 1'b1;
          state_nxt = ST_READ;
        end else if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          if (sts.head_valid) begin
            cmd.rel = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/byte_stream_reassembler_top.sv
// ---------------------------------------------------------------------------
// byte_stream_reassembler_top
// reorders bytes given at absolute stream positions into an in-order stream
// ---------------------------------------------------------------------------
// in_*: one byte at a 32-bit position, or an empty end marker; a byte inside
//   the 64-entry window ahead of the next expected position is stored
// out_*: per item, one transfer per released byte (out_out_valid high), or a
//   single status transfer with out_out_valid low; out_run_last marks the
//   last transfer of an item, with stream done and pending count after it
// an item is taken only when the previous item's results are all handed to
//   the output register, so one item is in work at a time
// timing: accept, a check of the head slot, then one byte per cycle out of
//   the ring read port while the receiver does not stall
// the first result is registered from the check state when nothing is
//   released; a released byte goes through the ring read register first
// reset clears valid bits, pointers and the output valid flag, not the output data
// a stalled receiver holds the output register and the release sequence
// ---------------------------------------------------------------------------
module byte_stream_reassembler_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bsr_pkg::POS_W-1:0]  in_position,
  input  logic [bsr_pkg::BYTE_W-1:0] in_byte_value,
  input  logic                      in_has_byte,
  input  logic                      in_ends_stream,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bsr_pkg::BYTE_W-1:0] out_out_byte,
  output logic                      out_out_valid,
  output logic                      out_run_last,
  output logic                      out_stream_done,
  output logic [bsr_pkg::CNT_W-1:0]  out_pending_count
);
  import bsr_pkg::*;

  bsr_cmd_t cmd;
  bsr_sts_t sts;

  bsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_position       (in_position),
    .in_byte_value     (in_byte_value),
    .in_has_byte       (in_has_byte),
    .in_ends_stream    (in_ends_stream),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_out_byte      (out_out_byte),
    .out_out_valid     (out_out_valid),
    .out_run_last      (out_run_last),
    .out_stream_done   (out_stream_done),
    .out_pending_count (out_pending_count)
  );

`include "byte_stream_reassembler_top_assert.svh"

  `BSR_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
  `BSR_ASSERT_IMP(a_empty_last, out_valid && !out_out_valid, out_run_last)
  `BSR_ASSERT_IMP(a_pend_cap, out_valid, out_pending_count <= CNT_W'(CAPACITY))
  `BSR_ASSERT_IMP(a_idle_last, in_ready && out_valid, out_run_last)

endmodule

### tb/byte_stream_reassembler_top_tb.sv
// ---------------------------------------------------------------------------
// byte_stream_reassembler_top_tb
// self-checking testbench for the byte stream reassembler
// ---------------------------------------------------------------------------
// A scoreboard keeps its own copy of the ring, the valid bits, the next
// expected position and the end marker. It computes the release run for
// every input transfer and compares each output transfer in order. The
// stimulus starts with directed cases: reordering, duplicates, bytes behind
// or past the window, end markers, repeated and dropped end flags. It then
// sends shuffled stream chunks, descending window fills and noise. The
// sender works in random bursts and the receiver stalls in changing
// patterns. A watchdog ends the run if nothing moves for too long.
// ---------------------------------------------------------------------------
module byte_stream_reassembler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsr_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 128;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_data;
    logic              run_last;
    logic              stream_done;
    logic [CNT_W-1:0]  pending;
  } out_beat_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PULSE,
    RX_HOLD
  } rx_mode_e;

  typedef enum int {
    SEQ_CHUNK,
    SEQ_FILL,
    SEQ_NOISE
  } seq_kind_e;

  class reasm_scoreboard;
    logic [BYTE_W-1:0] ring [RING_DEPTH];
    bit                slot_full [RING_DEPTH];
    logic [POS_W-1:0]  head_pos;
    bit                end_seen;
    logic [POS_W-1:0]  end_pos;
    int unsigned       stored;
    out_beat_t         stream_q[$];
    int                fail_count;

    function new();
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      head_pos   = '0;
      end_seen   = 1'b0;
      end_pos    = '0;
      stored     = 0;
      fail_count = 0;
    endfunction

    function int outstanding();
      return stream_q.size();
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void note_input(logic [POS_W-1:0] pos, logic [BYTE_W-1:0] val,
                             logic has, logic ends);
      logic [POS_W-1:0]   ahead;
      logic [RING_AW-1:0] slot;
      out_beat_t          beat;
      int                 n;
      if (ends) begin
        end_seen = 1'b1;
        end_pos  = pos + POS_W'(has);
      end
      if (has) begin
        ahead = pos - head_pos;
        if (ahead < CAPACITY) begin
          slot = pos[RING_AW-1:0];
          if (!slot_full[slot]) begin
            slot_full[slot] = 1'b1;
            stored++;
          end
          ring[slot] = val;
        end
      end
      n = 0;
      while (n < RING_DEPTH && slot_full[head_pos[RING_AW-1:0]]) begin
        slot = head_pos[RING_AW-1:0];
        slot_full[slot] = 1'b0;
        if (stored > 0) stored--;
        head_pos++;
        beat.data        = ring[slot];
        beat.has_data    = 1'b1;
        beat.run_last    = 1'b0;
        beat.stream_done = end_seen && (head_pos == end_pos);
        beat.pending     = CNT_W'(stored);
        stream_q         = {stream_q, beat};
        n++;
      end
      if (n == 0) begin
        beat.data        = '0;
        beat.has_data    = 1'b0;
        beat.run_last    = 1'b1;
        beat.stream_done = end_seen && (head_pos == end_pos);
        beat.pending     = CNT_W'(stored);
        stream_q         = {stream_q, beat};
      end else begin
        stream_q[stream_q.size() - 1].run_last = 1'b1;
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp;
      if (stream_q.size() == 0) begin
        flag($sformatf("unexpected output transfer: byte=%h vld=%b last=%b done=%b pend=%0d",
                       got.data, got.has_data, got.run_last, got.stream_done,
                       got.pending));
        return;
      end
      exp = stream_q.pop_front();
      if (got !== exp)
        flag($sformatf({"output mismatch: exp byte=%h vld=%b last=%b done=%b pend=%0d",
                        " got byte=%h vld=%b last=%b done=%b pend=%0d"},
                       exp.data, exp.has_data, exp.run_last, exp.stream_done,
                       exp.pending, got.data, got.has_data, got.run_last,
                       got.stream_done, got.pending));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [POS_W-1:0]  in_position;
  logic [BYTE_W-1:0] in_byte_value;
  logic              in_has_byte;
  logic              in_ends_stream;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_out_byte;
  logic              out_out_valid;
  logic              out_run_last;
  logic              out_stream_done;
  logic [CNT_W-1:0]  out_pending_count;

  reasm_scoreboard sb;
  int              burst_left;
  int              rx_left;
  rx_mode_e        rx_mode;
  int              quiet;

  byte_stream_reassembler_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_position      (in_position),
    .in_byte_value    (in_byte_value),
    .in_has_byte      (in_has_byte),
    .in_ends_stream   (in_ends_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_byte     (out_out_byte),
    .out_out_valid    (out_out_valid),
    .out_run_last     (out_run_last),
    .out_stream_done  (out_stream_done),
    .out_pending_count(out_pending_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(4, 40);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_PULSE: out_ready <= (rx_left % 3 == 0);
      default:  out_ready <= (rx_left >= 10);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_out_byte, out_out_valid, out_run_last, out_stream_done,
                        out_pending_count});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic put_item(input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] val,
                          input logic has, input logic ends);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_position    <= pos;
    in_byte_value  <= val;
    in_has_byte    <= has;
    in_ends_stream <= ends;
    do @(posedge clk); while (!in_ready);
    sb.note_input(pos, val, has, ends);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic run_directed();
    put_item(32'd0, 8'h00, 1'b0, 1'b0);
    put_item(32'd0, 8'h00, 1'b1, 1'b0);
    put_item(32'd3, 8'hFF, 1'b1, 1'b0);
    put_item(32'd2, 8'hA5, 1'b1, 1'b0);
    put_item(32'd3, 8'h5A, 1'b1, 1'b0);
    put_item(32'd1, 8'h3C, 1'b1, 1'b0);
    put_item(32'd2, 8'h11, 1'b1, 1'b0);
    put_item(32'd68, 8'h22, 1'b1, 1'b0);
    put_item(32'd67, 8'h80, 1'b1, 1'b0);
    put_item(32'hFFFF_FFFF, 8'h7F, 1'b1, 1'b0);
    put_item(32'h8000_0000, 8'h01, 1'b1, 1'b0);
    put_item(32'hFFFF_FFFF, 8'hC3, 1'b1, 1'b1);
    put_item(32'd6, 8'h00, 1'b0, 1'b1);
    put_item(32'd5, 8'h96, 1'b1, 1'b0);
    put_item(32'd4, 8'h69, 1'b1, 1'b0);
    put_item(32'd8, 8'hE7, 1'b1, 1'b0);
    put_item(32'd7, 8'h18, 1'b1, 1'b1);
    put_item(32'd9, 8'h00, 1'b0, 1'b1);
    put_item(32'd12, 8'hF0, 1'b1, 1'b0);
    put_item(32'd11, 8'h0F, 1'b1, 1'b0);
    put_item(32'd10, 8'hCC, 1'b1, 1'b0);
    put_item(32'd9, 8'h33, 1'b1, 1'b0);
  endtask

  task automatic run_random(input int target);
    int               ofs [CAPACITY];
    int               len, j, tmp, count, pick;
    bit               drained_mid;
    logic [POS_W-1:0] base;
    seq_kind_e        kind;
    count = 0;
    drained_mid = 1'b0;
    while (count < target) begin
      if (!drained_mid && count >= target / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 7);
      kind = (pick < 5) ? SEQ_CHUNK : (pick == 5) ? SEQ_FILL : SEQ_NOISE;
      base = sb.head_pos;
      case (kind)
        SEQ_CHUNK: begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) ofs[i] = i;
          for (int i = len - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = ofs[i];
            ofs[i] = ofs[j];
            ofs[j] = tmp;
          end
          for (int i = 0; i < len; i++) begin
            put_item(base + POS_W'(ofs[i]), BYTE_W'($urandom_range(0, 255)), 1'b1,
                     (i == len - 1) && ($urandom_range(0, 9) == 0));
            count++;
            if ($urandom_range(0, 9) == 0) begin
              put_item(base + POS_W'(ofs[i]), BYTE_W'($urandom_range(0, 255)), 1'b1,
                       1'b0);
              count++;
            end
          end
          if ($urandom_range(0, 3) == 0) begin
            put_item(base + POS_W'(len), BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            count++;
          end
        end
        SEQ_FILL: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, CAPACITY)
                                            : $urandom_range(2, 16);
          if (len > target - count + 1) len = target - count + 1;
          for (int i = len - 1; i >= 0; i--) begin
            put_item(base + POS_W'(i), BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
            count++;
          end
        end
        default: begin
          case ($urandom_range(0, 4))
            0: put_item(base - POS_W'($urandom_range(1, 100)),
                        BYTE_W'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
            1: put_item(base + POS_W'($urandom_range(CAPACITY, 1000)),
                        BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
            2: put_item(POS_W'($urandom()), BYTE_W'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            3: put_item(base + POS_W'(CAPACITY - 1), BYTE_W'($urandom_range(0, 255)),
                        1'b1, 1'b0);
            default: put_item(base + POS_W'($urandom_range(0, 20)),
                              BYTE_W'($urandom_range(0, 255)), 1'b0,
                              1'($urandom_range(0, 1)));
          endcase
          count++;
        end
      endcase
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_position    = '0;
    in_byte_value  = '0;
    in_has_byte    = 1'b0;
    in_ends_stream = 1'b0;
    out_ready      = 1'b0;
    burst_left     = 0;
    rx_left        = 0;
    rx_mode        = RX_OPEN;
    quiet          = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_drained();
    run_random(RANDOM_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.flag($sformatf("%0d expected transfers never arrived", sb.outstanding()));

    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
